FILE: rtl/tension_only_spring_force_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the spring force block
// Shared wrappers for clocked implication checks.
// ----------------------------------------------------------------------------
`ifndef TENSION_ONLY_SPRING_FORCE_ASSERT_SVH
`define TENSION_ONLY_SPRING_FORCE_ASSERT_SVH

// same-cycle implication
`define TOSF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TOSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tosf_pkg.sv
// ----------------------------------------------------------------------------
// tosf_pkg
// Widths, constants and carried types for the spring force pipeline.
// ----------------------------------------------------------------------------
package tosf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CRD_W     = 32;
    localparam int RATE_W    = 17;

    localparam int DW    = CRD_W + 1;
    localparam int SQW   = 2 * DW;
    localparam int SUMW  = SQW + 2;
    localparam int LW    = 34;
    localparam int SQ_N  = LW;
    localparam int TW    = CRD_W + RATE_W - FRAC_BITS;
    localparam int QW    = FRAC_BITS + 1;
    localparam int DV_N  = QW;
    localparam int RMW   = DW + FRAC_BITS;
    localparam int DSW   = LW + FRAC_BITS;
    localparam int PMW   = 2 * CRD_W;
    localparam int PPW   = CRD_W + LW;
    localparam int FULLW = PMW + LW;
    localparam int MW    = CRD_W + 1 + FRAC_BITS;
    localparam int UPW   = MW + QW;

    localparam int IN_W  = 312;
    localparam int OUT_W = 232;

    localparam logic [31:0] STIFF_RESET = 32'(64'd1 << FRAC_BITS);
    localparam logic [0:0]  REG_STIFF   = 1'b0;

    typedef struct packed {
        logic [2:0]            pos;
        logic [2:0]            nz;
        logic [2:0][DW-1:0]    d;
        logic [PMW-1:0]        pm_a;
        logic [PMW-1:0]        pm_b;
        logic [TW-1:0]         tgt;
    } car_t;

    typedef struct packed {
        logic          stretched;
        logic [LW-1:0] len;
        logic [LW-1:0] ex;
    } len_t;

endpackage

FILE: rtl/tension_only_spring_force.sv
// ----------------------------------------------------------------------------
// tension_only_spring_force
// Tension-only Hookean spring force for one muscle half-segment, Q16.16.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the output is not stalled and returns one result
// word per word, in order. The pipeline holds the 34-stage square root and the
// 17-stage divider for the unit vector; a stalled output word holds the
// whole pipeline in place. stiffness is written over APB at address 0.
module tension_only_spring_force import tosf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, mass_a, mass_b,
    // rest_length, contract_rate
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // force_a_x, force_a_y, force_a_z, force_b_x, force_b_y, force_b_z,
    // current_length, stretched
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NST = 3 + SQ_N + 1 + DV_N + 3;

    logic [31:0]      stiffness_reg;
    logic [NST-1:0]   vld_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             en;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_STIFF) ? stiffness_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiffness_reg <= STIFF_RESET;
            vld_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == REG_STIFF) begin
                stiffness_reg <= pwdata;
            end
            if (en) begin
                vld_reg      <= {vld_reg[NST-2:0], s_tvalid};
                m_tvalid_reg <= vld_reg[NST-1];
            end
        end
    end

    // stage 1: differences, mass products, target
    car_t s1_next, s1_car_reg;
    logic signed [DW-1:0] df [3];
    logic [RATE_W+CRD_W-1:0] rt_prod;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            df[i] = signed'({s_tdata[32*i+31], s_tdata[32*i +: 32]})
                  - signed'({s_tdata[96+32*i+31], s_tdata[96+32*i +: 32]});
            s1_next.d[i]   = df[i][DW-1] ? DW'(-df[i]) : DW'(df[i]);
            s1_next.nz[i]  = (df[i] != '0);
            s1_next.pos[i] = !df[i][DW-1] && (df[i] != '0);
        end
        s1_next.pm_a = PMW'(s_tdata[223:192]) * PMW'(stiffness_reg);
        s1_next.pm_b = PMW'(s_tdata[255:224]) * PMW'(stiffness_reg);
        rt_prod      = (RATE_W+CRD_W)'(s_tdata[304:288])
                     * (RATE_W+CRD_W)'(s_tdata[287:256]);
        s1_next.tgt  = rt_prod[RATE_W+CRD_W-1:FRAC_BITS];
    end

    // stages 2 and 3: squares, sum
    logic [SQW-1:0]  sq_reg [3];
    car_t            s2_car_reg, s3_car_reg;
    logic [SUMW-1:0] sum_reg;

    // square root, one result bit per stage
    logic [SUMW-1:0] sq_x_reg [SQ_N];
    logic [SUMW-1:0] sq_r_reg [SQ_N];
    car_t            sq_car_reg [SQ_N];
    logic [SUMW-1:0] sq_xi [SQ_N];
    logic [SUMW-1:0] sq_ri [SQ_N];
    logic [SUMW-1:0] sq_t [SQ_N];
    logic [SUMW-1:0] sq_one [SQ_N];
    logic [SUMW-1:0] sq_x_next [SQ_N];
    logic [SUMW-1:0] sq_r_next [SQ_N];

    always_comb begin
        for (int k = 0; k < SQ_N; k++) begin
            sq_xi[k]  = (k == 0) ? sum_reg : sq_x_reg[(k == 0) ? 0 : k-1];
            sq_ri[k]  = (k == 0) ? '0 : sq_r_reg[(k == 0) ? 0 : k-1];
            sq_one[k] = SUMW'(1) << (2 * (SQ_N - 1 - k));
            sq_t[k]   = sq_ri[k] + sq_one[k];
            if (sq_xi[k] >= sq_t[k]) begin
                sq_x_next[k] = sq_xi[k] - sq_t[k];
                sq_r_next[k] = (sq_ri[k] >> 1) + sq_one[k];
            end else begin
                sq_x_next[k] = sq_xi[k];
                sq_r_next[k] = sq_ri[k] >> 1;
            end
        end
    end

    // excess stage
    logic [LW-1:0]  len_w;
    logic [63:0]    len64, tgt64;
    len_t           e_next, e_len_reg;
    car_t           e_car_reg;
    logic [RMW-1:0] e_rem_reg [3];

    always_comb begin
        len_w            = sq_r_reg[SQ_N-1][LW-1:0];
        len64            = 64'(len_w);
        tgt64            = 64'(sq_car_reg[SQ_N-1].tgt);
        e_next.len       = len_w;
        e_next.stretched = (len64 > tgt64) && (len_w != '0);
        e_next.ex        = e_next.stretched ? LW'(len64 - tgt64) : '0;
    end

    // unit vector divider, one quotient bit per stage
    logic [RMW-1:0] dv_rem_reg [DV_N][3];
    logic [QW-1:0]  dv_q_reg [DV_N][3];
    len_t           dv_len_reg [DV_N];
    car_t           dv_car_reg [DV_N];
    logic [RMW-1:0] dv_rem_next [DV_N][3];
    logic [QW-1:0]  dv_q_next [DV_N][3];
    logic [DSW-1:0] dv_sh [DV_N];
    logic [DSW-1:0] dv_ri [DV_N][3];
    logic [QW-1:0]  dv_qi [DV_N][3];
    len_t           dv_li [DV_N];

    always_comb begin
        for (int j = 0; j < DV_N; j++) begin
            dv_li[j] = (j == 0) ? e_len_reg : dv_len_reg[(j == 0) ? 0 : j-1];
            dv_sh[j] = DSW'(dv_li[j].len) << (QW - 1 - j);
            for (int i = 0; i < 3; i++) begin
                dv_ri[j][i] = (j == 0) ? DSW'(e_rem_reg[i])
                                       : DSW'(dv_rem_reg[(j == 0) ? 0 : j-1][i]);
                dv_qi[j][i] = (j == 0) ? '0 : dv_q_reg[(j == 0) ? 0 : j-1][i];
                if (dv_ri[j][i] >= dv_sh[j]) begin
                    dv_rem_next[j][i] = RMW'(dv_ri[j][i] - dv_sh[j]);
                    dv_q_next[j][i]   = dv_qi[j][i] | (QW'(1) << (QW - 1 - j));
                end else begin
                    dv_rem_next[j][i] = RMW'(dv_ri[j][i]);
                    dv_q_next[j][i]   = dv_qi[j][i];
                end
            end
        end
    end

    // magnitude and component stages
    logic [PPW-1:0]   ma_lo_reg, ma_hi_reg, mb_lo_reg, mb_hi_reg;
    len_t             m1_len_reg, m2_len_reg, m3_len_reg;
    car_t             m1_car_reg, m2_car_reg, m3_car_reg;
    logic [QW-1:0]    m1_q_reg [3];
    logic [QW-1:0]    m2_q_reg [3];
    logic [MW-1:0]    mag_a_reg, mag_b_reg, mag_a_next, mag_b_next;
    logic [FULLW-1:0] full_a, full_b;
    logic [UPW-1:0]   up_a_reg [3];
    logic [UPW-1:0]   up_b_reg [3];
    localparam logic [MW-1:0] MAG_CAP = MW'(1) << (CRD_W + FRAC_BITS);

    always_comb begin
        full_a = ((FULLW'(ma_hi_reg) << 32) + FULLW'(ma_lo_reg)) >> (2 * FRAC_BITS);
        full_b = ((FULLW'(mb_hi_reg) << 32) + FULLW'(mb_lo_reg)) >> (2 * FRAC_BITS);
        mag_a_next = (full_a > FULLW'(MAG_CAP)) ? MAG_CAP : MW'(full_a);
        mag_b_next = (full_b > FULLW'(MAG_CAP)) ? MAG_CAP : MW'(full_b);
    end

    function automatic logic [31:0] sat_comp(input logic [UPW-1:0] p, input logic neg);
        logic [UPW-1:0] v;
        v = p >> FRAC_BITS;
        if (neg) begin
            sat_comp = (v >= UPW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(32'd0 - v[31:0]);
        end else begin
            sat_comp = (v > UPW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : v[31:0];
        end
    endfunction

    logic [31:0]      fa [3];
    logic [31:0]      fb [3];
    logic [31:0]      cur_len;
    logic [OUT_W-1:0] out_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fa[i] = m3_len_reg.stretched ? sat_comp(up_a_reg[i], m3_car_reg.pos[i]) : '0;
            fb[i] = m3_len_reg.stretched
                  ? sat_comp(up_b_reg[i], !m3_car_reg.pos[i] && m3_car_reg.nz[i]) : '0;
        end
        cur_len  = (m3_len_reg.len > LW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                         : m3_len_reg.len[31:0];
        out_next = {7'd0, m3_len_reg.stretched, cur_len,
                    fb[2], fb[1], fb[0], fa[2], fa[1], fa[0]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_car_reg <= s1_next;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SQW'(s1_car_reg.d[i]) * SQW'(s1_car_reg.d[i]);
            end
            s2_car_reg <= s1_car_reg;
            sum_reg    <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
            s3_car_reg <= s2_car_reg;
            for (int k = 0; k < SQ_N; k++) begin
                sq_x_reg[k]   <= sq_x_next[k];
                sq_r_reg[k]   <= sq_r_next[k];
                sq_car_reg[k] <= (k == 0) ? s3_car_reg : sq_car_reg[(k == 0) ? 0 : k-1];
            end
            e_len_reg <= e_next;
            e_car_reg <= sq_car_reg[SQ_N-1];
            for (int i = 0; i < 3; i++) begin
                e_rem_reg[i] <= RMW'(sq_car_reg[SQ_N-1].d[i]) << FRAC_BITS;
            end
            for (int j = 0; j < DV_N; j++) begin
                dv_len_reg[j] <= dv_li[j];
                dv_car_reg[j] <= (j == 0) ? e_car_reg : dv_car_reg[(j == 0) ? 0 : j-1];
                for (int i = 0; i < 3; i++) begin
                    dv_rem_reg[j][i] <= dv_rem_next[j][i];
                    dv_q_reg[j][i]   <= dv_q_next[j][i];
                end
            end
            ma_lo_reg  <= PPW'(dv_car_reg[DV_N-1].pm_a[31:0]) * PPW'(dv_len_reg[DV_N-1].ex);
            ma_hi_reg  <= PPW'(dv_car_reg[DV_N-1].pm_a[63:32]) * PPW'(dv_len_reg[DV_N-1].ex);
            mb_lo_reg  <= PPW'(dv_car_reg[DV_N-1].pm_b[31:0]) * PPW'(dv_len_reg[DV_N-1].ex);
            mb_hi_reg  <= PPW'(dv_car_reg[DV_N-1].pm_b[63:32]) * PPW'(dv_len_reg[DV_N-1].ex);
            m1_len_reg <= dv_len_reg[DV_N-1];
            m1_car_reg <= dv_car_reg[DV_N-1];
            mag_a_reg  <= mag_a_next;
            mag_b_reg  <= mag_b_next;
            m2_len_reg <= m1_len_reg;
            m2_car_reg <= m1_car_reg;
            for (int i = 0; i < 3; i++) begin
                m1_q_reg[i] <= dv_q_reg[DV_N-1][i];
                m2_q_reg[i] <= m1_q_reg[i];
                up_a_reg[i] <= UPW'(mag_a_reg) * UPW'(m2_q_reg[i]);
                up_b_reg[i] <= UPW'(mag_b_reg) * UPW'(m2_q_reg[i]);
            end
            m3_len_reg  <= m2_len_reg;
            m3_car_reg  <= m2_car_reg;
            m_tdata_reg <= out_next;
        end
    end

endmodule

FILE: rtl/tosf_checker.sv
// ----------------------------------------------------------------------------
// tosf_checker
// Port-level checks for the spring force block, bound to the top level.
// ----------------------------------------------------------------------------
`include "tension_only_spring_force_assert.svh"

module tosf_checker import tosf_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tvalid,
    input logic             m_tready
);

    `TOSF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
    `TOSF_ASSERT_IMPL(a_stall_in, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "input taken while pipeline stalled")
    `TOSF_ASSERT_IMPL(a_slack_zero, aclk, aresetn, m_tvalid && !m_tdata[224], m_tdata[191:0] == '0, "force on slack spring")
    `TOSF_ASSERT_IMPL(a_len_nz, aclk, aresetn, m_tvalid && m_tdata[224], m_tdata[223:192] != '0, "stretched with zero length")

endmodule

bind tension_only_spring_force tosf_checker u_tosf_checker (.*);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tension-only spring force pipeline: a directed
// stimulus table then random spring halves, each result word checked against
// an in-bench force predictor or a table entry, under varying stream stalls and stiffness.
// ----------------------------------------------------------------------------
module tb_top import tosf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] rate_pad;
        logic [31:0] rest;
        logic [31:0] mb;
        logic [31:0] ma;
        logic [5:0][31:0] pos;
    } spring_t;

    typedef struct packed {
        logic        stretched;
        logic [31:0] len;
        logic [5:0][31:0] frc;
    } force_t;

    typedef struct {
        spring_t sp;
        bit      has_exp;
        force_t  ex;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [IN_W-1:0] s_tdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [OUT_W-1:0] m_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    logic [31:0] stiff_model = STIFF_RESET;
    force_t expected_forces[$];
    int mismatches = 0;
    int src_idle = 0, snk_idle = 0;
    row_t dir_rows[$];

    tension_only_spring_force uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [33:0] isqrt(logic [67:0] s);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            if (68'(c) * 68'(c) <= s) r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] axis_force(logic [48:0] mag, logic [16:0] u, bit neg);
        logic [65:0] p;
        p = (66'(mag) * 66'(u)) >> FRAC_BITS;
        if (neg) return (p >= 66'h80000000) ? 32'h80000000 : 32'(-p);
        return (p > 66'h7fffffff) ? 32'h7fffffff : p[31:0];
    endfunction

    function automatic logic [48:0] pull(logic [31:0] m, logic [33:0] ex);
        logic [97:0] p;
        p = (98'(m) * 98'(stiff_model) * 98'(ex)) >> (2 * FRAC_BITS);
        return (p > (98'd1 << (32 + FRAC_BITS))) ? 49'd1 << (32 + FRAC_BITS) : p[48:0];
    endfunction

    function automatic force_t spring_force(spring_t sp);
        force_t r;
        logic signed [32:0] dv;
        logic [32:0] d[3];
        bit up[3];
        logic [67:0] sum;
        logic [33:0] len;
        logic [48:0] tgt;
        logic [48:0] mga, mgb;
        logic [16:0] u;
        r = '0;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            dv = $signed({sp.pos[i][31], sp.pos[i]}) - $signed({sp.pos[3+i][31], sp.pos[3+i]});
            up[i] = dv > 0;
            d[i] = dv < 0 ? 33'(-dv) : 33'(dv);
            sum += 68'(d[i]) * 68'(d[i]);
        end
        len = isqrt(sum);
        tgt = (49'(sp.rate_pad[16:0]) * 49'(sp.rest)) >> FRAC_BITS;
        r.len = len > 34'hffffffff ? 32'hffffffff : len[31:0];
        if (len == 0 || 49'(len) <= tgt) return r;
        r.stretched = 1'b1;
        mga = pull(sp.ma, len - 34'(tgt));
        mgb = pull(sp.mb, len - 34'(tgt));
        for (int i = 0; i < 3; i++) begin
            u = 17'((51'(d[i]) << FRAC_BITS) / 51'(len));
            r.frc[i] = axis_force(mga, u, up[i]);
            r.frc[3+i] = axis_force(mgb, u, !up[i] && d[i] != 0);
        end
        return r;
    endfunction

    task automatic apb_write(logic [31:0] v);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(REG_STIFF) << 2; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        stiff_model = v;
    endtask

    task automatic send_spring(spring_t sp);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= IN_W'(sp);
        s_tvalid <= 1'b1;
        expected_forces = {expected_forces, spring_force(sp)};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_forces.size() != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    function automatic spring_t rand_spring();
        spring_t sp;
        int sh;
        sh = $urandom_range(31);
        for (int i = 0; i < 6; i++) sp.pos[i] = $urandom >>> sh;
        if ($urandom_range(3) == 0) sp.pos = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        sp.ma = $urandom >> $urandom_range(31);
        sp.mb = $urandom >> $urandom_range(31);
        sp.rest = $urandom >> $urandom_range(31);
        sp.rate_pad = 32'($urandom_range(17'h1ffff));
        if ($urandom_range(1)) sp.rate_pad = 32'($urandom_range(17'h10000));
        return sp;
    endfunction

    always @(posedge aclk) begin
        force_t got, ex;
        if (aresetn) m_tready <= ($urandom_range(99) >= snk_idle);
        if (m_tvalid && m_tready) begin
            got = m_tdata[$bits(force_t)-1:0];
            if (expected_forces.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
            end else begin
                ex = expected_forces.pop_front();
                if (got !== ex) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h got %h", ex, got);
                end
            end
        end
    end

    task automatic add_row(spring_t sp, bit he, force_t ex);
        row_t r;
        r.sp = sp; r.has_exp = he; r.ex = ex;
        dir_rows = {dir_rows, r};
    endtask

    initial begin
        spring_t sp;
        force_t z;
        logic [31:0] stiff_set[4] = '{32'h0, 32'hffffffff, 32'h00028000, 32'h00000100};
        z = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // coincident vertices: zero length, no force
        sp = '0; sp.ma = '1; sp.mb = '1;
        add_row(sp, 1, z);
        // unit length along x, target above: slack
        sp = '0; sp.pos[0] = 32'h10000; sp.rest = 32'h20000; sp.rate_pad = 32'h10000;
        z.len = 32'h10000; add_row(sp, 1, z);
        // length equal to target: still slack
        sp.rest = 32'h10000; add_row(sp, 1, z);
        // stretched, unit mass and stiffness, rest zero: force 1.0 each end
        sp.rest = 0; sp.ma = 32'h10000; sp.mb = 32'h10000;
        z.stretched = 1; z.frc[0] = 32'hffff0000; z.frc[3] = 32'h00010000;
        add_row(sp, 1, z);
        // extremes of position: long distance saturates length
        sp = '0;
        sp.pos = {32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        sp.ma = '1; sp.mb = '1; add_row(sp, 0, z);
        sp.pos = {32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000};
        sp.rest = '1; sp.rate_pad = 32'h1ffff; add_row(sp, 0, z);
        sp.rate_pad = 32'h0; add_row(sp, 0, z);
        // rate above one, each axis alone, negative offsets
        for (int i = 0; i < 6; i++) begin
            sp = '0; sp.pos[i] = (i % 2) ? 32'hfff00000 : 32'h00300000;
            sp.ma = 32'h28000; sp.mb = 32'h8000; sp.rest = 32'h8000;
            sp.rate_pad = 32'h18000; add_row(sp, 0, z);
        end
        sp = '0; sp.pos[0] = 32'h1; sp.pos[4] = 32'hffffffff; sp.ma = '1; sp.rest = '1;
        sp.rate_pad = 32'h1; add_row(sp, 0, z);

        foreach (dir_rows[k]) begin
            send_spring(dir_rows[k].sp);
            if (dir_rows[k].has_exp) begin
                expected_forces[expected_forces.size() - 1] = dir_rows[k].ex;
            end
        end
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 32 : (ph == 1) ? 57 : 0;
            snk_idle = (ph == 0) ? 57 : (ph == 1) ? 32 : 0;
            for (int s = 0; s < 4; s++) begin
                apb_write((ph == 2 && s == 3) ? $urandom : stiff_set[s]);
                for (int n = 0; n < 92; n++) send_spring(rand_spring());
                drain();
            end
        end

        if (mismatches == 0 && expected_forces.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/tosf_pkg.sv
rtl/tension_only_spring_force.sv
rtl/tosf_checker.sv
tb/tb_top.sv
